>>> rtl/core/window_function_generator_core_assert.svh
// Assertion macros shared by the window function generator RTL.
`ifndef WINDOW_FUNCTION_GENERATOR_CORE_ASSERT_SVH
`define WINDOW_FUNCTION_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window generator check failed");

`endif

>>> rtl/core/wfg_pkg.sv
// Shared constants and types of the window function generator.
`default_nettype none

package wfg_pkg;

    localparam int X_BITS    = 16;
    localparam int FRAC_BITS = 16;
    localparam int W_BITS    = 18;
    localparam int Q_BITS    = 30;
    localparam int CHI_W     = FRAC_BITS + 1;
    localparam int PADDR_W   = 3;
    localparam int LANES     = 3;
    localparam int HORN_N    = 5;
    localparam int LSTG      = HORN_N + 2;
    localparam int SQ_BITS   = 32;

    localparam logic [X_BITS-1:0] XMAX_RST = X_BITS'(65535);

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF = 31'h2000_0000;
    localparam logic [31:0] QTURN    = 32'h4000_0000;

    // sin(pi/2*z) coefficients, Q30 magnitudes
    localparam logic [31:0] SC1  = 32'd1686629713;
    localparam logic [31:0] SC3  = 32'd693598668;
    localparam logic [31:0] SC5  = 32'd85569306;
    localparam logic [31:0] SC7  = 32'd5026995;
    localparam logic [31:0] SC9  = 32'd172270;
    localparam logic [31:0] SC11 = 32'd3863;
    localparam logic [31:0] HORN_C [HORN_N] = '{SC9, SC7, SC5, SC3, SC1};
    localparam logic [31:0] TWO_SC1 = 32'd3373259426;

    // Nuttall coefficients, Q30
    localparam logic signed [31:0] NA0 = 32'sd382002981;
    localparam logic signed [31:0] NA_K [LANES] = '{32'sd523337470, 32'sd154867931,
                                                    32'sd13533442};

    typedef enum logic [2:0] {
        FORM_NONE     = 3'd0,
        FORM_BARTLETT = 3'd1,
        FORM_HANN     = 3'd2,
        FORM_LANCZOS  = 3'd3,
        FORM_NUTTALL  = 3'd4,
        FORM_TAPER    = 3'd5,
        FORM_LORCH    = 3'd6
    } t_form;

    localparam logic REG_FORM = 1'b0;
    localparam logic REG_XMAX = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/wfg_in_if.sv
// Abscissa input channel of the window function generator.
`default_nettype none

interface wfg_in_if
    import wfg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [X_BITS-1:0] x_pos;

    modport source (output valid, output x_pos, input ready);
    modport sink   (input valid, input x_pos, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wfg_out_if.sv
// Weight output channel of the window function generator.
`default_nettype none

interface wfg_out_if
    import wfg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [W_BITS-1:0] weight;
    logic              out_of_range;

    modport source (output valid, output weight, output out_of_range, input ready);
    modport sink   (input valid, input weight, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> rtl/core/window_function_generator_core.sv
// Window function generator: pipelined window weight per abscissa beat.
//
// Usage: write window_form (byte address 0) and x_max (byte address 4) over
// the APB port while the block is idle, then stream abscissa beats on i_in.
// Each accepted beat yields exactly one beat on o_out: a Q.16 signed weight
// (clamped to [-1, 1]) and an out_of_range flag set when x_pos > x_max.
// Throughput: one beat per clock while the receiver keeps up. Depth is set
// by the bit-per-stage divider for x_pos/x_max (16 stages), the seven-stage
// sine polynomial lanes and the bit-per-stage sinc divider (32 stages).
// Reset (synchronous, active low) empties the pipeline and loads
// window_form = none and x_max = 65535; no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds in place and
// i_in.ready drops for as long as a finished result waits unclaimed at the
// output register; bubbles inside the pipeline are not squeezed out.
`default_nettype none
`include "window_function_generator_core_assert.svh"

module window_function_generator_core
    import wfg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    wfg_in_if.sink                  i_in,
    wfg_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Pipeline depth: divider entry + steps, phase stage, lanes, Nuttall
    // products, sinc divider entry + steps, output register.
    localparam int NV = (FRAC_BITS + 1) + 1 + LSTG + 1 + (SQ_BITS + 1) + 1;

    typedef struct packed {
        logic [30:0] u;     // sinc argument (or Bartlett distance)
        logic        low;   // sinc argument at or below one half
        logic        oor;
        logic [31:0] den;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [2:0]        r_form;
    logic [X_BITS-1:0] r_xmax;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form <= FORM_NONE;
            r_xmax <= XMAX_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FORM: r_form <= pwdata[2:0];
                REG_XMAX: r_xmax <= pwdata[X_BITS-1:0];
                default:  r_form <= r_form;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FORM: prdata = {29'd0, r_form};
            REG_XMAX: prdata = 32'(r_xmax);
            default:  prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Advance everything together unless a finished beat sits unclaimed.
    logic          adv;
    logic          acc;
    logic [NV-1:0] r_v;

    assign adv        = !r_v[NV-1] || o_out.ready;
    assign i_in.ready = adv;
    assign acc        = i_in.valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NV-2:0], acc};
        end
    end

    // ---------------- chi = x_pos / x_max, one quotient bit per stage ----------
    logic [X_BITS-1:0]    r_dr   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_dq   [0:FRAC_BITS];
    logic                 r_dge  [0:FRAC_BITS];
    logic                 r_door [0:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dr[0]   <= i_in.x_pos;
            r_dq[0]   <= '0;
            r_dge[0]  <= i_in.x_pos >= r_xmax;
            r_door[0] <= i_in.x_pos > r_xmax;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_cdiv
        logic [X_BITS:0] t;
        logic            ge;
        assign t  = {r_dr[k-1], 1'b0};
        assign ge = t >= {1'b0, r_xmax};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dr[k]   <= ge ? X_BITS'(t - {1'b0, r_xmax}) : t[X_BITS-1:0];
                r_dq[k]   <= {r_dq[k-1][FRAC_BITS-2:0], ge};
                r_dge[k]  <= r_dge[k-1];
                r_door[k] <= r_door[k-1];
            end
        end
    end

    // ---------------- phase stage ----------------
    logic [CHI_W-1:0] n_chi;
    logic [30:0]      n_chi30;
    logic [31:0]      n_ph;
    logic [31:0]      n_tw;
    logic [30:0]      n_ul;
    logic [30:0]      n_u;
    logic [31:0]      n_zs;
    logic [31:0]      n_lph [LANES];
    logic [31:0]      r_ph  [LANES];
    t_side            r_sd  [0:LSTG];

    always_comb begin
        n_chi   = r_dge[FRAC_BITS] ? CHI_W'(1) << FRAC_BITS : {1'b0, r_dq[FRAC_BITS]};
        n_chi30 = 31'(n_chi) << (Q_BITS - FRAC_BITS);
        n_ph    = {n_chi30[29:0], 2'b00};
        n_tw    = {n_chi30, 1'b0};
        n_ul    = (n_tw >= 32'(Q30_ONE)) ? 31'(n_tw - 32'(Q30_ONE))
                                         : 31'(32'(Q30_ONE) - n_tw);
        n_u     = (r_form == FORM_LORCH) ? n_chi30 : n_ul;
        // fold sinc argument onto the quarter wave
        n_zs    = (n_u <= Q30_HALF) ? {n_u, 1'b0} : {31'(Q30_ONE - n_u), 1'b0};
        for (int l = 0; l < LANES; l++) begin
            n_lph[l] = '0;
        end
        case (r_form)
            FORM_HANN, FORM_NUTTALL: begin
                n_lph[0] = n_ph + QTURN;
                n_lph[1] = {n_ph[30:0], 1'b0} + QTURN;
                n_lph[2] = n_ph + {n_ph[30:0], 1'b0} + QTURN;
            end
            FORM_TAPER: begin
                n_lph[0] = 32'(n_chi30);
            end
            FORM_LANCZOS, FORM_LORCH: begin
                n_lph[0] = n_zs;
            end
            default: begin
                n_lph[0] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_ph[l] <= n_lph[l];
            end
            r_sd[0].u   <= n_u;
            r_sd[0].low <= n_u <= Q30_HALF;
            r_sd[0].oor <= r_door[FRAC_BITS];
            r_sd[0].den <= '0;
        end
    end

    // ---------------- sine lanes: fold, square, Horner, final product --------
    logic [30:0] r_lz   [LANES][0:HORN_N];
    logic [30:0] r_lz2  [LANES][0:HORN_N-1];
    logic [31:0] r_lq   [LANES][0:HORN_N];
    logic        r_lneg [LANES][0:LSTG-1];
    logic [31:0] r_ls   [LANES];
    logic [31:0] r_sq0;

    logic [30:0] n_z   [LANES];
    logic [61:0] n_zz  [LANES];
    logic [62:0] n_hm  [LANES][HORN_N];
    logic [62:0] n_sm  [LANES];
    logic [62:0] n_den;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_z[l]  = r_ph[l][30] ? 31'(Q30_ONE - 31'(r_ph[l][29:0])) : 31'(r_ph[l][29:0]);
            n_zz[l] = 62'(n_z[l]) * 62'(n_z[l]);
            for (int j = 0; j < HORN_N; j++) begin
                n_hm[l][j] = 63'(r_lz2[l][j]) * 63'(r_lq[l][j]);
            end
            n_sm[l] = 63'(r_lz[l][HORN_N]) * 63'(r_lq[l][HORN_N]);
        end
        n_den = 63'(TWO_SC1) * 63'(r_sd[0].u);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_lz[l][0]   <= n_z[l];
                r_lz2[l][0]  <= n_zz[l][60:30];
                r_lq[l][0]   <= SC11;
                r_lneg[l][0] <= r_ph[l][31];
                for (int j = 1; j <= HORN_N; j++) begin
                    r_lz[l][j] <= r_lz[l][j-1];
                    r_lq[l][j] <= HORN_C[j-1] - 32'(n_hm[l][j-1][62:30]);
                end
                for (int j = 1; j < HORN_N; j++) begin
                    r_lz2[l][j] <= r_lz2[l][j-1];
                end
                for (int j = 1; j < LSTG; j++) begin
                    r_lneg[l][j] <= r_lneg[l][j-1];
                end
                r_ls[l] <= n_sm[l][61:30];
            end
            r_sq0 <= r_lq[0][HORN_N];
            r_sd[1] <= {r_sd[0].u, r_sd[0].low, r_sd[0].oor, n_den[61:30]};
            for (int j = 2; j <= LSTG; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
    end

    // ---------------- form combine: Nuttall products and simple forms --------
    localparam logic signed [34:0] W_ONE = 35'sh4000_0000;

    logic signed [33:0] n_c  [LANES];
    logic signed [63:0] n_p  [LANES];
    logic signed [34:0] n_ws;
    logic signed [63:0] r_cp [LANES];
    logic signed [34:0] r_cws;
    logic [31:0]        r_cnum;
    logic [31:0]        r_cdiv;
    logic               r_coor;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_c[l] = r_lneg[l][LSTG-1] ? -$signed({2'b00, r_ls[l]})
                                       : $signed({2'b00, r_ls[l]});
            n_p[l] = 64'(NA_K[l]) * 64'(n_c[l]);
        end
        case (r_form)
            FORM_NONE:     n_ws = W_ONE;
            FORM_BARTLETT: n_ws = W_ONE - $signed({4'b0000, r_sd[LSTG].u});
            FORM_HANN:     n_ws = (W_ONE - 35'(n_c[0])) >>> 1;
            FORM_TAPER:    n_ws = W_ONE - 35'(n_c[0]);
            default:       n_ws = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_cp[l] <= n_p[l];
            end
            r_cws  <= n_ws;
            r_cnum <= r_sd[LSTG].low ? r_sq0 : r_ls[0];
            r_cdiv <= r_sd[LSTG].low ? SC1 : r_sd[LSTG].den;
            r_coor <= r_sd[LSTG].oor;
        end
    end

    // Nuttall sum with products truncated toward zero
    logic signed [63:0] n_pb [LANES];
    logic signed [34:0] n_pt [LANES];
    logic signed [34:0] n_nut;
    logic signed [34:0] n_wo;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_pb[l] = r_cp[l] + (r_cp[l][63] ? 64'sh3FFF_FFFF : 64'sd0);
            n_pt[l] = 35'(n_pb[l] >>> Q_BITS);
        end
        n_nut = 35'(NA0) - n_pt[0] + n_pt[1] - n_pt[2];
        n_wo  = (r_form == FORM_NUTTALL) ? n_nut : r_cws;
    end

    // ---------------- sinc divider, one quotient bit per stage ----------------
    logic [31:0]        r_sr    [0:SQ_BITS];
    logic [31:0]        r_sq    [0:SQ_BITS];
    logic [31:0]        r_sdv   [0:SQ_BITS];
    logic signed [34:0] r_sw    [0:SQ_BITS];
    logic               r_ssinc [0:SQ_BITS];
    logic               r_soor  [0:SQ_BITS];
    logic [1:0]         r_snl   [0:1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // top bits of num<<30 lie below the divisor; start from them
            r_sr[0]    <= {2'b00, r_cnum[31:2]};
            r_snl[0]   <= r_cnum[1:0];
            r_sq[0]    <= '0;
            r_sdv[0]   <= r_cdiv;
            r_sw[0]    <= n_wo;
            r_ssinc[0] <= (r_form == FORM_LANCZOS) || (r_form == FORM_LORCH);
            r_soor[0]  <= r_coor;
            r_snl[1]   <= r_snl[0];
        end
    end

    for (genvar k = 1; k <= SQ_BITS; k++) begin : g_sdiv
        logic        nbit;
        logic [32:0] t;
        logic        ge;
        if (k == 1) begin : g_b1
            assign nbit = r_snl[0][1];
        end else if (k == 2) begin : g_b0
            assign nbit = r_snl[1][0];
        end else begin : g_bz
            assign nbit = 1'b0;
        end
        assign t  = {r_sr[k-1], nbit};
        assign ge = t >= {1'b0, r_sdv[k-1]};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sr[k]    <= ge ? 32'(t - {1'b0, r_sdv[k-1]}) : t[31:0];
                r_sq[k]    <= {r_sq[k-1][30:0], ge};
                r_sdv[k]   <= r_sdv[k-1];
                r_sw[k]    <= r_sw[k-1];
                r_ssinc[k] <= r_ssinc[k-1];
                r_soor[k]  <= r_soor[k-1];
            end
        end
    end

    // ---------------- round to Q.16, clamp, output register ----------------
    logic signed [34:0] n_w;
    logic [34:0]        n_mag;
    logic [20:0]        n_m;
    logic [16:0]        n_mc;
    logic [W_BITS-1:0]  n_wt;
    logic [W_BITS-1:0]  r_ow;
    logic               r_ooor;

    always_comb begin
        n_w   = r_ssinc[SQ_BITS] ? $signed({3'b000, r_sq[SQ_BITS]}) : r_sw[SQ_BITS];
        n_mag = n_w[34] ? 35'(-n_w) : 35'(n_w);
        n_m   = 21'((n_mag + 35'd8192) >> 14);
        n_mc  = (n_m > 21'd65536) ? 17'd65536 : 17'(n_m);
        n_wt  = n_w[34] ? W_BITS'(-$signed({1'b0, n_mc})) : W_BITS'({1'b0, n_mc});
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ow   <= n_wt;
            r_ooor <= r_soor[SQ_BITS];
        end
    end

    assign o_out.valid        = r_v[NV-1];
    assign o_out.weight       = r_ow;
    assign o_out.out_of_range = r_ooor;

    // ---------------- assertions ----------------
    logic wt_ok;

    assign wt_ok = ($signed(o_out.weight) >= -18'sd65536) &&
                   ($signed(o_out.weight) <= 18'sd65536);

    `WFG_ASSERT_NEXT(a_stall_freezes_pipe, i_clk, i_rst_n, !adv, $stable(r_v))
    `WFG_ASSERT_IMPL(a_weight_in_range, i_clk, i_rst_n, o_out.valid, wt_ok)

endmodule

`default_nettype wire

>>> bench/window_function_generator_core_test.sv
// Self-checking testbench for the window function generator core.
`timescale 1ns / 1ps

module window_function_generator_core_test;
    import wfg_pkg::*;

    localparam int         DRAIN       = 70;   // more than the pipeline latency
    localparam longint     ONE30       = 64'sd1 << 30;

    // Magnitudes of the sine polynomial terms, widened for 64-bit math.
    localparam longint K1  = longint'(SC1);
    localparam longint K3  = longint'(SC3);
    localparam longint K5  = longint'(SC5);
    localparam longint K7  = longint'(SC7);
    localparam longint K9  = longint'(SC9);
    localparam longint K11 = longint'(SC11);

    typedef struct packed {
        logic [W_BITS-1:0] weight;
        logic              out_of_range;
    } weight_beat_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    wfg_in_if  in_ch ();
    wfg_out_if out_ch ();

    window_function_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block's registers; touched only while the block is idle.
    logic [2:0]        form_shadow = FORM_NONE;
    logic [X_BITS-1:0] xmax_shadow = XMAX_RST;

    logic [X_BITS-1:0] abscissa_q[$];
    weight_beat_t      weights_due[$];
    int                error_count = 0;
    int                idle_mode = 0;   // 0: receiver idles most, 1: sender idles most, 2: none

    // ---------------------------------------------------------------
    // Fixed-point window arithmetic
    // ---------------------------------------------------------------

    // Even factor of sin(pi/2*z), Horner form in Q30.
    function automatic longint sin_even(longint z2);
        longint q;
        q = K9 - ((z2 * K11) >>> 30);
        q = K7 - ((z2 * q) >>> 30);
        q = K5 - ((z2 * q) >>> 30);
        q = K3 - ((z2 * q) >>> 30);
        q = K1 - ((z2 * q) >>> 30);
        return q;
    endfunction

    function automatic longint quarter_sine(longint z);
        return (z * sin_even((z * z) >>> 30)) >>> 30;
    endfunction

    // Sine of a phase in turns (Q32, wrapping), Q30 signed.
    function automatic longint sine_turns(logic [31:0] phase);
        longint r;
        longint s;
        r = longint'(phase[29:0]);
        s = quarter_sine(phase[30] ? ONE30 - r : r);
        return phase[31] ? -s : s;
    endfunction

    function automatic longint cosine_turns(logic [31:0] phase);
        return sine_turns(phase + QTURN);
    endfunction

    // sin(pi*u)/(pi*u), u in Q30 from 0 to 1; no division by u near zero.
    function automatic longint sinc_q30(longint u);
        longint s;
        if (u <= (ONE30 >>> 1)) begin
            s = ((2 * u) * (2 * u)) >>> 30;
            return (sin_even(s) <<< 30) / K1;
        end
        s = quarter_sine((ONE30 - u) * 2);
        return (s <<< 30) / ((2 * K1 * u) >>> 30);
    endfunction

    function automatic weight_beat_t window_weight(logic [2:0] form, logic [X_BITS-1:0] xmax,
                                                   logic [X_BITS-1:0] x);
        weight_beat_t b;
        longint chi;
        longint chi30;
        longint w;
        longint d;
        longint m;
        logic [31:0] ph;
        // Saturate the fraction at the end of the window; zero x_max lands here too.
        chi   = (x >= xmax) ? (64'sd1 << FRAC_BITS)
                            : (longint'(x) <<< FRAC_BITS) / longint'(xmax);
        chi30 = chi <<< (Q_BITS - FRAC_BITS);
        ph    = 32'(chi30 <<< 2);
        d     = 2 * chi30 - ONE30;
        if (d < 0) d = -d;
        case (form)
            FORM_NONE:     w = ONE30;
            FORM_BARTLETT: w = ONE30 - d;
            FORM_HANN:     w = (ONE30 - cosine_turns(ph)) / 2;
            FORM_LANCZOS:  w = sinc_q30(d);
            FORM_NUTTALL:  w = longint'(NA0)
                              - (longint'(NA_K[0]) * cosine_turns(ph)) / ONE30
                              + (longint'(NA_K[1]) * cosine_turns(ph * 32'd2)) / ONE30
                              - (longint'(NA_K[2]) * cosine_turns(ph * 32'd3)) / ONE30;
            FORM_TAPER:    w = ONE30 - sine_turns(32'(chi30));
            FORM_LORCH:    w = sinc_q30(chi30);
            default:       w = 0;
        endcase
        // Round Q30 to Q16, halves away from zero, then clamp to [-1, 1].
        m = (((w < 0) ? -w : w) + 8192) >>> 14;
        if (w < 0) m = -m;
        if (m < -65536) m = -65536;
        if (m > 65536) m = 65536;
        b.weight       = W_BITS'(m);
        b.out_of_range = (x > xmax);
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Input driver: advance to the next pending abscissa after each beat,
    // drop valid at random to open gaps.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.x_pos <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                weights_due.push_back(window_weight(form_shadow, xmax_shadow, in_ch.x_pos));
            if (!in_ch.valid || in_ch.ready) begin
                if (abscissa_q.size() != 0 &&
                    !(idle_mode == 0 && $urandom_range(99) < 31) &&
                    !(idle_mode == 1 && $urandom_range(99) < 61)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.x_pos <= abscissa_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: stall at random, check each beat against the oldest weight due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (weights_due.size() == 0) begin
                    report_mismatch("unexpected beat", 32'(out_ch.weight), 32'd0);
                end else begin
                    weight_beat_t want;
                    want = weights_due.pop_front();
                    if (out_ch.weight !== want.weight)
                        report_mismatch("weight", 32'(out_ch.weight), 32'(want.weight));
                    if (out_ch.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", 32'(out_ch.out_of_range),
                                        32'(want.out_of_range));
                end
            end
            out_ch.ready <= !((idle_mode == 0 && $urandom_range(99) < 61) ||
                              (idle_mode == 1 && $urandom_range(99) < 31));
        end
    end

    // ---------------------------------------------------------------
    // Register access and sequencing
    // ---------------------------------------------------------------
    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FORM) form_shadow = value[2:0];
        else                 xmax_shadow = value[X_BITS-1:0];
    endtask

    // Hold until every beat is out, then let the pipeline drain.
    // Sample on the falling edge so the driver's updates have settled.
    task automatic wait_idle();
        while (abscissa_q.size() != 0 || in_ch.valid || weights_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] form, logic [X_BITS-1:0] xmax);
        wait_idle();
        write_reg(REG_FORM, 32'(form));
        write_reg(REG_XMAX, 32'(xmax));
    endtask

    initial begin
        logic [X_BITS-1:0] xm;
        int                phases;
        in_ch.valid  = 1'b0;
        in_ch.x_pos  = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values first, then every form at the window
        // center, both ends and just past the end.
        abscissa_q = '{16'd0, 16'd65535};
        for (int f = 0; f < 8; f++) begin
            configure(3'(f), 16'd1000);
            abscissa_q = '{16'd0, 16'd500, 16'd1000, 16'd1001};
        end

        // Random phases; three of every six pin x_max to 0, 1 and 65535.
        phases = 24;
        for (int p = 0; p < phases; p++) begin
            idle_mode = (p * 3) / phases;
            case (p % 6)
                0:       xm = 16'd0;
                1:       xm = 16'd1;
                2:       xm = 16'hFFFF;
                default: xm = 16'($urandom_range(65535));
            endcase
            configure(3'($urandom_range(7)), xm);
            for (int i = 0; i < 70; i++) begin
                if ($urandom_range(3) == 0)
                    abscissa_q.push_back(16'($urandom_range(65535)));
                else
                    abscissa_q.push_back(16'($urandom_range(32'(xm))));
            end
            // Lanczos and Lorch sinc zero points for this phase.
            abscissa_q.push_back(xm >> 1);
            abscissa_q.push_back(16'd0);
        end

        wait_idle();
        if (error_count == 0)
            $display("window_function_generator_core_test: clean");
        else
            $display("window_function_generator_core_test: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("window_function_generator_core_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wfg_pkg.sv
rtl/core/wfg_in_if.sv
rtl/core/wfg_out_if.sv
rtl/core/window_function_generator_core.sv
bench/window_function_generator_core_test.sv
